// File: rtl/uld_pkg.sv
`default_nettype none

package uld_pkg;

  localparam int PREFIX_LEN     = 7;
  localparam int PREFIX_W       = 3;
  localparam int RETURN_RUN_MAX = 62;
  localparam int HELD_W         = 6;
  localparam int RESULT_CAP     = 63;
  localparam int COUNT_W        = 6;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] HEX_RADIX    = 8'd16;

  typedef enum logic [1:0] {
    MODE_PREFIX = 2'd0,
    MODE_PATH   = 2'd1,
    MODE_SKIP   = 2'd2
  } line_mode_t;

  typedef enum logic [1:0] {
    PH_NONE     = 2'd0,
    PH_PCT      = 2'd1,
    PH_PCT_CHAR = 2'd2
  } pct_phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RELEASE,
    ST_FEED,
    ST_FLUSH,
    ST_CLOSE,
    ST_CLOSE2,
    ST_END
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_DISPATCH,
    OP_RELEASE,
    OP_FEED,
    OP_CLOSE_PCT,
    OP_CLOSE_FIRST,
    OP_FLUSH,
    OP_END
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
  } uld_cmd_t;

  typedef struct packed {
    line_mode_t line_mode;
    pct_phase_t phase;
    logic       byte_is_cr;
    logic       byte_is_lf;
    logic       last;
    logic       held_zero;
    logic       held_one;
    logic       prefix_done;
    logic       out_free;
  } uld_status_t;

  function automatic logic [7:0] prefix_char(input logic [PREFIX_W-1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h66; // f
      3'd1:    ch = 8'h69; // i
      3'd2:    ch = 8'h6C; // l
      3'd3:    ch = 8'h65; // e
      3'd4:    ch = 8'h3A; // :
      3'd5:    ch = 8'h2F; // /
      3'd6:    ch = 8'h2F; // /
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [7:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      v = 8'h00;
    end
    return v;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    return (c == CHAR_PLUS) || (c == CHAR_MINUS);
  endfunction

  // two characters read as a base-16 number, modulo 256
  function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] v;
    v = 8'h00;
    if (is_blank(a)) begin
      if (is_hex(b)) v = hex_nib(b);
    end else if (is_sign(a)) begin
      if (is_hex(b)) v = (a == CHAR_MINUS) ? 8'(8'h00 - hex_nib(b)) : hex_nib(b);
    end else if (is_hex(a)) begin
      if (is_hex(b)) v = 8'(hex_nib(a) * HEX_RADIX) + hex_nib(b);
      else           v = hex_nib(a);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/uld_ctrl.sv
`default_nettype none

module uld_ctrl
  import uld_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        text_valid,
  output logic             text_stall,
  input  wire uld_status_t status,
  output uld_cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    text_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (text_valid) begin
          cmd.op     = OP_LATCH;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.op = OP_DISPATCH;
        case (status.line_mode)
          MODE_PREFIX: begin
            // a final byte that completes the prefix closes an empty path
            if (!status.byte_is_lf && status.last && status.prefix_done) state_next = ST_END;
            else state_next = ST_IDLE;
          end
          MODE_PATH: begin
            if (status.byte_is_cr) state_next = status.last ? ST_CLOSE : ST_IDLE;
            else if (status.byte_is_lf) state_next = ST_CLOSE;
            else state_next = status.held_zero ? ST_FEED : ST_RELEASE;
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_RELEASE: begin
        if (status.out_free) begin
          cmd.op     = OP_RELEASE;
          state_next = status.held_one ? ST_FEED : ST_RELEASE;
        end
      end
      ST_FEED: begin
        if (status.out_free) begin
          cmd.op     = OP_FEED;
          state_next = status.last ? ST_CLOSE : ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.op     = OP_FLUSH;
          state_next = ST_IDLE;
        end
      end
      ST_CLOSE: begin
        if (status.phase == PH_NONE) begin
          state_next = ST_END;
        end else if (status.out_free) begin
          cmd.op     = OP_CLOSE_PCT;
          state_next = (status.phase == PH_PCT_CHAR) ? ST_CLOSE2 : ST_END;
        end
      end
      ST_CLOSE2: begin
        if (status.out_free) begin
          cmd.op     = OP_CLOSE_FIRST;
          state_next = ST_END;
        end
      end
      ST_END: begin
        if (status.out_free) begin
          cmd.op     = OP_END;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/uld_datapath.sv
`default_nettype none

module uld_datapath
  import uld_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] text_byte,
  input  wire logic       last_of_data,
  input  wire uld_cmd_t   cmd,
  output uld_status_t     status,
  output logic            path_valid,
  input  wire logic       path_stall,
  output logic [7:0]      path_byte,
  output logic            byte_valid,
  output logic            path_end
);

  line_mode_t          line_mode;
  line_mode_t          line_mode_next;
  logic [PREFIX_W-1:0] prefix_matched;
  logic [PREFIX_W-1:0] prefix_matched_next;
  logic [HELD_W-1:0]   held_returns;
  logic [HELD_W-1:0]   held_returns_next;
  pct_phase_t          percent_phase;
  pct_phase_t          percent_phase_next;
  logic [7:0]          percent_first;
  logic [7:0]          percent_first_next;
  logic [COUNT_W-1:0]  emit_count;
  logic [COUNT_W-1:0]  emit_count_next;
  logic [7:0]          cur_byte;
  logic                cur_last;
  logic [7:0]          hold_byte;
  logic                out_free;
  logic                prefix_hit;
  logic                emit_req;
  logic [7:0]          emit_byte;
  logic [7:0]          feed_byte;
  logic                emit_take;
  logic                push;
  logic [7:0]          push_byte;
  logic                push_valid;
  logic                push_end;

  assign out_free   = !path_valid || !path_stall;
  assign prefix_hit = (32'(prefix_matched) < PREFIX_LEN) &&
                      (cur_byte == prefix_char(prefix_matched));
  assign feed_byte  = (cmd.op == OP_RELEASE) ? CHAR_CR : cur_byte;

  always_comb begin
    status.line_mode   = line_mode;
    status.phase       = percent_phase;
    status.byte_is_cr  = (cur_byte == CHAR_CR);
    status.byte_is_lf  = (cur_byte == CHAR_LF);
    status.last        = cur_last;
    status.held_zero   = (held_returns == '0);
    status.held_one    = (held_returns == HELD_W'(1));
    status.prefix_done = prefix_hit && (prefix_matched == PREFIX_W'(PREFIX_LEN - 1));
    status.out_free    = out_free;
  end

  always_comb begin
    line_mode_next      = line_mode;
    prefix_matched_next = prefix_matched;
    held_returns_next   = held_returns;
    percent_phase_next  = percent_phase;
    percent_first_next  = percent_first;
    emit_req            = 1'b0;
    emit_byte           = 8'h00;
    push                = 1'b0;
    push_byte           = hold_byte;
    push_valid          = 1'b1;
    push_end            = 1'b0;
    case (cmd.op)
      OP_DISPATCH: begin
        case (line_mode)
          MODE_PREFIX: begin
            if (cur_byte == CHAR_LF) begin
              prefix_matched_next = '0;
            end else if (prefix_hit) begin
              prefix_matched_next = prefix_matched + PREFIX_W'(1);
              if (status.prefix_done) line_mode_next = MODE_PATH;
              else if (cur_last) prefix_matched_next = '0;
            end else if (cur_last) begin
              prefix_matched_next = '0;
            end else begin
              line_mode_next = MODE_SKIP;
            end
          end
          MODE_PATH: begin
            if (cur_byte == CHAR_CR && held_returns < HELD_W'(RETURN_RUN_MAX)) begin
              held_returns_next = held_returns + HELD_W'(1);
            end
          end
          default: begin
            if (cur_byte == CHAR_LF || cur_last) begin
              line_mode_next      = MODE_PREFIX;
              prefix_matched_next = '0;
            end
          end
        endcase
      end
      OP_RELEASE, OP_FEED: begin
        if (cmd.op == OP_RELEASE) held_returns_next = held_returns - HELD_W'(1);
        case (percent_phase)
          PH_NONE: begin
            if (feed_byte == CHAR_PERCENT) begin
              percent_phase_next = PH_PCT;
            end else begin
              emit_req  = 1'b1;
              emit_byte = feed_byte;
            end
          end
          PH_PCT: begin
            percent_first_next = feed_byte;
            percent_phase_next = PH_PCT_CHAR;
          end
          default: begin
            emit_req           = 1'b1;
            emit_byte          = decode_pair(percent_first, feed_byte);
            percent_phase_next = PH_NONE;
            percent_first_next = 8'h00;
          end
        endcase
      end
      OP_CLOSE_PCT: begin
        emit_req  = 1'b1;
        emit_byte = CHAR_PERCENT;
      end
      OP_CLOSE_FIRST: begin
        emit_req  = 1'b1;
        emit_byte = percent_first;
      end
      OP_FLUSH: begin
        push = (emit_count != '0);
      end
      OP_END: begin
        push     = 1'b1;
        push_end = 1'b1;
        if (emit_count == '0) begin
          push_byte  = 8'h00;
          push_valid = 1'b0;
        end
        line_mode_next      = MODE_PREFIX;
        prefix_matched_next = '0;
        held_returns_next   = '0;
        percent_phase_next  = PH_NONE;
        percent_first_next  = 8'h00;
      end
      default: ;
    endcase
    // results beyond the cap are dropped; the held one moves out when a new one arrives
    emit_take = emit_req && (32'(emit_count) < RESULT_CAP);
    if (emit_take && emit_count != '0) push = 1'b1;
    if (cmd.op == OP_LATCH) emit_count_next = '0;
    else if (emit_take) emit_count_next = emit_count + COUNT_W'(1);
    else emit_count_next = emit_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_mode      <= MODE_PREFIX;
      prefix_matched <= '0;
      held_returns   <= '0;
      percent_phase  <= PH_NONE;
      percent_first  <= 8'h00;
      emit_count     <= '0;
      path_valid     <= 1'b0;
    end else begin
      line_mode      <= line_mode_next;
      prefix_matched <= prefix_matched_next;
      held_returns   <= held_returns_next;
      percent_phase  <= percent_phase_next;
      percent_first  <= percent_first_next;
      emit_count     <= emit_count_next;
      if (push) path_valid <= 1'b1;
      else if (!path_stall) path_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) begin
      cur_byte <= text_byte;
      cur_last <= last_of_data;
    end
    if (emit_take) hold_byte <= emit_byte;
    if (push) begin
      path_byte  <= push_byte;
      byte_valid <= push_valid;
      path_end   <= push_end;
    end
  end

endmodule

`default_nettype wire

// File: rtl/uri_list_path_decoder_top.sv
// uri-list path decoder: takes a text/uri-list stream one byte per request and sends out
// the decoded path of every line that starts with file://, one byte per result request,
// the last result of a path carrying path_end (a bare prefix line gives one end marker
// with byte_valid low). a byte that gives no result is accepted and dispatched; any other
// path byte first releases the held CRs through the percent decoder, is fed through it and
// is flushed, or closes the line if it is the last; closing a line emits a pending percent
// sign and its first character, then the end mark. uld_ctrl steps this, moving one result
// a cycle via a one-entry hold register into the output register while path_stall is low.
`default_nettype none

module uri_list_path_decoder_top
  import uld_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       text_valid,
  output logic            text_stall,
  input  wire logic [7:0] text_byte,
  input  wire logic       last_of_data,
  output logic            path_valid,
  input  wire logic       path_stall,
  output logic [7:0]      path_byte,
  output logic            byte_valid,
  output logic            path_end
);

  // commands from the sequencer, status back from the datapath
  uld_cmd_t    cmd;
  uld_status_t status;

  // sequencer: one step of the current byte per cycle unless the result side stalls
  uld_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // line state, percent decoding, hold and output registers
  uld_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .text_byte    (text_byte),
    .last_of_data (last_of_data),
    .cmd          (cmd),
    .status       (status),
    .path_valid   (path_valid),
    .path_stall   (path_stall),
    .path_byte    (path_byte),
    .byte_valid   (byte_valid),
    .path_end     (path_end)
  );

  // an end marker always closes a path
  a_marker_ends : assert property (@(posedge clk) disable iff (rst)
    (path_valid && !byte_valid) |-> path_end)
    else $error("end marker without path_end");

  // an end marker carries a zero byte
  a_marker_zero : assert property (@(posedge clk) disable iff (rst)
    (path_valid && !byte_valid) |-> (path_byte == 8'h00))
    else $error("end marker with non-zero byte");

  // an accepted request keeps the input side busy in the next cycle
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (text_valid && !text_stall) |=> text_stall)
    else $error("input taken again straight after a request");

endmodule

`default_nettype wire

// File: tb/sv/uri_list_path_decoder_top_tb.sv
module uri_list_path_decoder_top_tb;
  import uld_pkg::*;

  // stimulus shape
  localparam int OPENING_ROWS    = 26;
  localparam int RANDOM_REQS     = 300;
  localparam int IDLE_PCT        = 7;
  // requests in this window go with no idling on either side
  localparam int STEADY_FROM     = 100;
  localparam int STEADY_TO       = 180;
  // the receiver holds off once this many requests are in, so the block backs up
  localparam int LONG_HOLD_AT    = 60;
  localparam int HOLD_OFF_CYCLES = 250;
  // the sender stops here until every expected path byte has arrived
  localparam int PAUSE_AT        = 200;
  // the tail is long enough for a released run of returns, so it covers the longest
  localparam int TAIL_CYCLES     = 100;
  // longest quiet spell in a correct run is the hold-off plus the tail; take it many times
  localparam int WATCHDOG_LIMIT  = 4000;

  localparam logic [8*PREFIX_LEN-1:0] FILE_PREFIX = "file://";

  // one text request, with an optional typed result for the opening rows
  typedef struct packed {
    logic [7:0] tbyte;
    logic       tlast;
    logic       typed;
    logic       has_res;
    logic [7:0] rbyte;
    logic       rvalid;
    logic       rend;
  } text_req_t;

  typedef struct packed {
    logic [7:0] pbyte;
    logic       bvalid;
    logic       pend;
  } path_res_t;

  // opening rows: typed results where they are obvious, the rest go through the predictor
  localparam text_req_t OPENING [OPENING_ROWS] = '{
    // lone line feed straight after reset gives nothing
    '{CHAR_LF, 0, 1, 0, 8'h00, 0, 0},
    '{"f", 0, 1, 0, 8'h00, 0, 0},
    '{"i", 0, 1, 0, 8'h00, 0, 0},
    '{"l", 0, 1, 0, 8'h00, 0, 0},
    '{"e", 0, 1, 0, 8'h00, 0, 0},
    '{":", 0, 1, 0, 8'h00, 0, 0},
    '{"/", 0, 1, 0, 8'h00, 0, 0},
    // bare prefix closed by the final-byte flag: just the end marker
    '{"/", 1, 1, 1, 8'h00, 0, 1},
    // carriage return inside the prefix spoils the line
    '{"f", 0, 1, 0, 8'h00, 0, 0},
    '{CHAR_CR, 0, 1, 0, 8'h00, 0, 0},
    '{CHAR_LF, 0, 1, 0, 8'h00, 0, 0},
    '{"f", 0, 1, 0, 8'h00, 0, 0},
    '{"i", 0, 1, 0, 8'h00, 0, 0},
    '{"l", 0, 1, 0, 8'h00, 0, 0},
    '{"e", 0, 1, 0, 8'h00, 0, 0},
    '{":", 0, 1, 0, 8'h00, 0, 0},
    '{"/", 0, 1, 0, 8'h00, 0, 0},
    '{"/", 0, 1, 0, 8'h00, 0, 0},
    // byte extremes pass straight through
    '{8'hFF, 0, 1, 1, 8'hFF, 1, 0},
    '{8'h00, 0, 1, 1, 8'h00, 1, 0},
    // held return released by a percent sign, then a negative pair
    '{CHAR_CR, 0, 1, 0, 8'h00, 0, 0},
    '{CHAR_PERCENT, 0, 0, 0, 8'h00, 0, 0},
    '{CHAR_MINUS, 0, 0, 0, 8'h00, 0, 0},
    '{"a", 0, 0, 0, 8'h00, 0, 0},
    // percent sign left dangling when the data ends
    '{CHAR_PERCENT, 0, 0, 0, 8'h00, 0, 0},
    '{CHAR_LF, 1, 0, 0, 8'h00, 0, 0}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       text_valid = 1'b0;
  logic       text_stall;
  logic [7:0] text_byte = 8'h00;
  logic       last_of_data = 1'b0;
  logic       path_valid;
  logic       path_stall = 1'b0;
  logic [7:0] path_byte;
  logic       byte_valid;
  logic       path_end;

  uri_list_path_decoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .last_of_data (last_of_data),
    .path_valid   (path_valid),
    .path_stall   (path_stall),
    .path_byte    (path_byte),
    .byte_valid   (byte_valid),
    .path_end     (path_end)
  );

  always #10 clk = ~clk;

  text_req_t text_q[$];     // every request, in sending order
  path_res_t decoded_q[$];  // path results still awaited
  path_res_t step_q[$];     // results of the request being predicted

  int errors      = 0;
  int taken_n     = 0;
  int idle_cycles = 0;
  int hold_left   = 0;
  bit held_once   = 1'b0;

  // decoder state as the predictor sees it
  line_mode_t mode     = MODE_PREFIX;
  int         pfx_seen = 0;
  int         cr_held  = 0;
  pct_phase_t pct      = PH_NONE;
  logic [7:0] pct_char = 8'h00;

  text_req_t cur_req;
  path_res_t want_res;
  path_res_t got_res;

  function automatic logic [7:0] prefix_byte(input int k);
    return FILE_PREFIX[8*(PREFIX_LEN-1-k) +: 8];
  endfunction

  function automatic int nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  // two characters read as a base-16 number the strtol way, modulo 256
  function automatic logic [7:0] pair_value(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] s [2];
    int k;
    int acc;
    logic neg;
    s[0] = a;
    s[1] = b;
    k = 0;
    acc = 0;
    neg = 1'b0;
    while (k < 2 && (s[k] == CHAR_SPACE || (s[k] >= 8'h09 && s[k] <= CHAR_CR))) k++;
    if (k < 2 && (s[k] == CHAR_PLUS || s[k] == CHAR_MINUS)) begin
      neg = (s[k] == CHAR_MINUS);
      k++;
    end
    while (k < 2 && nibble(s[k]) >= 0) begin
      acc = acc * int'(HEX_RADIX) + nibble(s[k]);
      k++;
    end
    if (neg) acc = 256 - acc;
    return acc[7:0];
  endfunction

  task automatic emit_byte(input logic [7:0] b);
    path_res_t r;
    if (step_q.size() < RESULT_CAP) begin
      r = '{b, 1'b1, 1'b0};
      step_q.insert(step_q.size(), r);
    end
  endtask

  task automatic clear_line();
    mode     = MODE_PREFIX;
    pfx_seen = 0;
    cr_held  = 0;
    pct      = PH_NONE;
    pct_char = 8'h00;
  endtask

  // one path character through the percent decoder
  task automatic take_char(input logic [7:0] c);
    case (pct)
      PH_NONE: begin
        if (c == CHAR_PERCENT) pct = PH_PCT;
        else emit_byte(c);
      end
      PH_PCT: begin
        pct_char = c;
        pct = PH_PCT_CHAR;
      end
      default: begin
        emit_byte(pair_value(pct_char, c));
        pct = PH_NONE;
        pct_char = 8'h00;
      end
    endcase
  endtask

  task automatic close_path();
    path_res_t r;
    if (pct == PH_PCT) begin
      emit_byte(CHAR_PERCENT);
    end else if (pct == PH_PCT_CHAR) begin
      emit_byte(CHAR_PERCENT);
      emit_byte(pct_char);
    end
    if (step_q.size() > 0) begin
      step_q[step_q.size()-1].pend = 1'b1;
    end else begin
      r = '{8'h00, 1'b0, 1'b1};
      step_q.insert(step_q.size(), r);
    end
    clear_line();
  endtask

  // results caused by one text byte, left in step_q
  task automatic decode_text_byte(input logic [7:0] c, input logic last);
    step_q.delete();
    case (mode)
      MODE_PREFIX: begin
        if (c == CHAR_LF) begin
          clear_line();
        end else begin
          if (pfx_seen < PREFIX_LEN && c == prefix_byte(pfx_seen)) begin
            pfx_seen++;
            if (pfx_seen == PREFIX_LEN) mode = MODE_PATH;
          end else begin
            mode = MODE_SKIP;
          end
          if (last) begin
            if (mode == MODE_PATH) close_path();
            else clear_line();
          end
        end
      end
      MODE_PATH: begin
        if (c == CHAR_CR) begin
          if (cr_held < RETURN_RUN_MAX) cr_held++;
        end else if (c != CHAR_LF) begin
          while (cr_held > 0) begin
            take_char(CHAR_CR);
            cr_held--;
          end
          take_char(c);
        end
        if (c == CHAR_LF || last) close_path();
      end
      default: begin
        if (c == CHAR_LF || last) clear_line();
      end
    endcase
  endtask

  // ---- random line builder ----

  task automatic put(input logic [7:0] b);
    text_req_t r;
    r = '0;
    r.tbyte = b;
    text_q.insert(text_q.size(), r);
  endtask

  task automatic put_returns(input int n);
    for (int k = 0; k < n; k++) put(CHAR_CR);
  endtask

  // second or third character of a percent escape: half hex, the rest blanks, signs and random bytes
  function automatic logic [7:0] escape_char();
    string hexdigits = "0123456789abcdefABCDEF";
    case ($urandom_range(5))
      0, 1, 2: return hexdigits[$urandom_range(21)];
      3:       return $urandom_range(1) ? CHAR_SPACE : 8'($urandom_range(9, 13));
      4:       return $urandom_range(1) ? CHAR_PLUS : CHAR_MINUS;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one line of uri-list text: mostly file:// paths with random content, then
  // spoilt prefixes, noise and empty lines; with_long forces a saturating return run
  task automatic make_line(input bit with_long);
    int kind;
    int elems;
    int n;
    int start;
    start = text_q.size();
    kind = with_long ? 0 : $urandom_range(99);
    elems = 0;
    if (kind < 70) begin
      for (int k = 0; k < PREFIX_LEN; k++) put(prefix_byte(k));
      elems = $urandom_range(0, 10);
    end else if (kind < 80) begin
      n = $urandom_range(0, PREFIX_LEN - 1);
      for (int k = 0; k < n; k++) put(prefix_byte(k));
      put(8'($urandom_range(255)));
      elems = $urandom_range(0, 4);
    end else if (kind < 92) begin
      n = $urandom_range(1, 8);
      for (int k = 0; k < n; k++) put(8'($urandom_range(255)));
    end
    for (int k = 0; k < elems; k++) begin
      case ($urandom_range(9))
        0, 1, 2: put(8'($urandom_range(8'h21, 8'h7E)));
        3:       put(8'($urandom_range(255)));
        4, 5: begin
          put(CHAR_PERCENT);
          put(escape_char());
          put(escape_char());
        end
        6: begin
          put(CHAR_PERCENT);
          put(escape_char());
        end
        7:       put_returns($urandom_range(1, 3));
        8:       put_returns(($urandom_range(19) == 0) ? $urandom_range(58, 70) : 1);
        default: put(CHAR_PERCENT);
      endcase
    end
    if (with_long) begin
      put_returns(RETURN_RUN_MAX + $urandom_range(1, 6));
      put(CHAR_PERCENT);
    end
    // line ending: plain LF, trailing returns, or the final-byte flag
    case ($urandom_range(9))
      7: begin
        put_returns($urandom_range(1, 3));
        put(CHAR_LF);
      end
      8: begin
        if (text_q.size() == start) put(CHAR_LF);
        text_q[text_q.size()-1].tlast = 1'b1;
      end
      9: begin
        put(CHAR_LF);
        text_q[text_q.size()-1].tlast = 1'b1;
      end
      default: put(CHAR_LF);
    endcase
  endtask

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %02h, got %02h", $time, field, want, got);
    end
  endtask

  // ---- sender ----
  initial begin
    int i;
    bit paused;
    for (int k = 0; k < OPENING_ROWS; k++) text_q.insert(text_q.size(), OPENING[k]);
    while (text_q.size() < OPENING_ROWS + RANDOM_REQS) make_line(text_q.size() == OPENING_ROWS);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    i = 0;
    paused = 1'b0;
    while (i < text_q.size()) begin
      if (i == PAUSE_AT && !paused) begin
        // let the block drain completely before going on
        paused = 1'b1;
        text_valid <= 1'b0;
        do @(posedge clk); while (decoded_q.size() != 0);
      end else if (!(i >= STEADY_FROM && i < STEADY_TO) && $urandom_range(99) < IDLE_PCT) begin
        text_valid <= 1'b0;
        @(posedge clk);
      end else begin
        text_valid   <= 1'b1;
        text_byte    <= text_q[i].tbyte;
        last_of_data <= text_q[i].tlast;
        do @(posedge clk); while (text_stall);
        i++;
      end
    end
    text_valid <= 1'b0;

    // drain, then give any trailing activity time to show itself
    do @(posedge clk); while (decoded_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("uri_list_path_decoder_top: match");
    end else begin
      $display("uri_list_path_decoder_top: mismatch");
    end
    $finish;
  end

  // ---- receiver: random stalls, a steady window and one long hold-off ----
  always @(posedge clk) begin
    if (!held_once && taken_n >= LONG_HOLD_AT) begin
      held_once <= 1'b1;
      hold_left <= HOLD_OFF_CYCLES;
      path_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      path_stall <= 1'b1;
    end else if (taken_n >= STEADY_FROM && taken_n < STEADY_TO) begin
      path_stall <= 1'b0;
    end else begin
      path_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // ---- accepted text bytes feed the predictor ----
  always @(posedge clk) begin
    if (!rst && text_valid && !text_stall) begin
      cur_req = text_q[taken_n];
      decode_text_byte(cur_req.tbyte, cur_req.tlast);
      if (cur_req.typed) begin
        if (cur_req.has_res) begin
          want_res = '{cur_req.rbyte, cur_req.rvalid, cur_req.rend};
          decoded_q.insert(decoded_q.size(), want_res);
        end
      end else begin
        foreach (step_q[k]) decoded_q.insert(decoded_q.size(), step_q[k]);
      end
      taken_n++;
    end
  end

  // ---- accepted path results against the oldest expectation ----
  always @(posedge clk) begin
    if (!rst && path_valid && !path_stall) begin
      got_res = '{path_byte, byte_valid, path_end};
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: expected no result, got %02h valid %0b end %0b",
                 $time, got_res.pbyte, got_res.bvalid, got_res.pend);
      end else begin
        want_res = decoded_q.pop_front();
        check_field("path_byte", want_res.pbyte, got_res.pbyte);
        check_field("byte_valid", 8'(want_res.bvalid), 8'(got_res.bvalid));
        check_field("path_end", 8'(want_res.pend), 8'(got_res.pend));
      end
    end
  end

  // ---- watchdog: too long with nothing accepted on either side ----
  always @(posedge clk) begin
    if ((text_valid && !text_stall) || (path_valid && !path_stall)) begin
      idle_cycles <= 0;
    end else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("uri_list_path_decoder_top: mismatch");
        $finish;
      end
    end
  end

endmodule

// File: uri_list_path_decoder_top.f
rtl/uld_pkg.sv
rtl/uld_ctrl.sv
rtl/uld_datapath.sv
rtl/uri_list_path_decoder_top.sv
tb/sv/uri_list_path_decoder_top_tb.sv
